[design/kua_pkg.sv]
// ----------------------------------------------------------------------------
// kua_pkg: shared types and constants of the keyed usage accumulator
// Table size, field widths, operation, result and register codes, the slot
// record and the cell command set.
// ----------------------------------------------------------------------------
package kua_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 32;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int MAX_OUT       = 32;
	localparam int HITS_W        = $clog2(MAX_OUT + 1);

	// field widths
	localparam int OP_W    = 2;
	localparam int ID_W    = 22;
	localparam int SCPU_W  = 16;
	localparam int SMEM_W  = 10;
	localparam int CPU_W   = 24;
	localparam int MEM_W   = 18;
	localparam int KIND_W  = 2;

	// configuration widths
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_W      = 13;
	localparam int CPU_LIM_W  = 13;
	localparam int MEM_LIM_W  = 7;
	localparam int WIN_W      = 8;
	localparam int CPU_L10_W  = CPU_LIM_W + 4;
	localparam int MEM_L10_W  = MEM_LIM_W + 4;
	localparam int CPU_THR_W  = CPU_L10_W + WIN_W;
	localparam int MEM_THR_W  = MEM_L10_W + WIN_W;

	// limits times ten after reset (limit 50 each), window 5
	localparam logic [CPU_L10_W-1:0] CPU_L10_RST = CPU_L10_W'(500);
	localparam logic [MEM_L10_W-1:0] MEM_L10_RST = MEM_L10_W'(500);
	localparam logic [WIN_W-1:0]     WIN_RST     = WIN_W'(5);

	// operation codes
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
	localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_TAKEN   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SUSPECT = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CPU_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEM_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd2;

	// one table slot
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [CPU_W-1:0] cpu;
		logic [MEM_W-1:0] mem;
		logic             trusted;
	} slot_t;

	// per-cell command
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_ADD,
		CMD_CLAIM,
		CMD_SHIFT
	} cell_cmd_t;

endpackage

[design/keyed_usage_accumulator_unit.sv]
// ----------------------------------------------------------------------------
// keyed_usage_accumulator_unit: per-process usage table with threshold report
// Top level: request sequencing, configuration, thresholds and result
// register around the ring of table cells.
// ----------------------------------------------------------------------------
// A clear request completes when it is accepted. A sample request passes
// through accept, parallel id match across all cells, and cell update with
// result load, and gives one result; the update waits on any output stall.
// A report request rotates the table one slot per cycle past the head cell,
// where the threshold test is made, except while a held hit waits for a busy
// output, and a full rotation leaves the table as it was. Results pass
// through one output register, so a request can be accepted while the
// previous result still waits. Slots are always filled from index 0 upward,
// so a fill count stands for the used flags and a clear only resets that
// count. Configuration writes are always taken; the thresholds are then
// recomputed into their own registers from the stored limit and window.
module keyed_usage_accumulator_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [kua_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kua_pkg::CFG_W-1:0]          cfg_data,
	// requests
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [kua_pkg::OP_W-1:0]           operation,
	input  logic [kua_pkg::ID_W-1:0]           proc_id,
	input  logic [kua_pkg::SCPU_W-1:0]         cpu_tenths,
	input  logic [kua_pkg::SMEM_W-1:0]         mem_tenths,
	input  logic                               is_trusted,
	// results
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [kua_pkg::KIND_W-1:0]         kind,
	output logic [kua_pkg::ID_W-1:0]           out_id,
	output logic [kua_pkg::CPU_W-1:0]          cpu_total,
	output logic [kua_pkg::MEM_W-1:0]          mem_total,
	output logic                               last
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_UPDATE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t state_q;

	// configuration and thresholds
	logic [kua_pkg::CPU_L10_W-1:0] cpu_lim10_q;
	logic [kua_pkg::MEM_L10_W-1:0] mem_lim10_q;
	logic [kua_pkg::WIN_W-1:0]     win_q;
	logic [kua_pkg::CPU_THR_W-1:0] cpu_thr_q;
	logic [kua_pkg::MEM_THR_W-1:0] mem_thr_q;

	// request and table control
	kua_pkg::slot_t                      req_q;
	logic [kua_pkg::CNT_W-1:0]           count_q;
	logic [kua_pkg::TABLE_ENTRIES-1:0]   hit_q;
	logic                                hit_any_q;
	logic [kua_pkg::IDX_W-1:0]           scan_idx_q;
	logic [kua_pkg::HITS_W-1:0]          nhits_q;
	kua_pkg::slot_t                      pend_q;
	logic                                pend_valid_q;

	// result register
	logic                                out_valid_q;
	logic [kua_pkg::KIND_W-1:0]          kind_q;
	logic [kua_pkg::ID_W-1:0]            out_id_q;
	logic [kua_pkg::CPU_W-1:0]           cpu_total_q;
	logic [kua_pkg::MEM_W-1:0]           mem_total_q;
	logic                                last_q;

	// row signals
	kua_pkg::cell_cmd_t [kua_pkg::TABLE_ENTRIES-1:0] cmds;
	logic [kua_pkg::TABLE_ENTRIES-1:0]   match;
	logic [kua_pkg::TABLE_ENTRIES-1:0]   used;
	kua_pkg::slot_t                      head;
	logic [kua_pkg::CPU_W-1:0]           sel_cpu;
	logic [kua_pkg::MEM_W-1:0]           sel_mem;

	logic out_free;
	logic out_load;
	logic accept;
	logic head_hit;
	logic scan_step;
	logic table_full;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid & in_ready;
	assign out_free  = ~out_valid_q | out_ready;
	assign table_full = (count_q == kua_pkg::CNT_W'(kua_pkg::TABLE_ENTRIES));

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign out_id    = out_id_q;
	assign cpu_total = cpu_total_q;
	assign mem_total = mem_total_q;
	assign last      = last_q;

	// used flags from the fill count
	always_comb begin
		for (int i = 0; i < kua_pkg::TABLE_ENTRIES; i++) begin
			used[i] = (kua_pkg::CNT_W'(i) < count_q);
		end
	end

	// threshold test on the slot now at the head of the ring
	always_comb begin
		head_hit = (kua_pkg::CNT_W'(scan_idx_q) < count_q) & ~head.trusted
			& ((kua_pkg::CPU_THR_W'(head.cpu) > cpu_thr_q)
			| (kua_pkg::MEM_THR_W'(head.mem) > mem_thr_q))
			& (nhits_q < kua_pkg::HITS_W'(kua_pkg::MAX_OUT));
	end

	// the ring stalls only when a held hit must go out and the output is busy
	assign scan_step = (state_q == ST_SCAN) & (~(head_hit & pend_valid_q) | out_free);

	// a new result enters the output register this cycle
	assign out_load = ((state_q == ST_UPDATE) & out_free)
		| (scan_step & head_hit & pend_valid_q)
		| ((state_q == ST_FLUSH) & out_free);

	// per-cell commands
	always_comb begin
		for (int i = 0; i < kua_pkg::TABLE_ENTRIES; i++) begin
			cmds[i] = kua_pkg::CMD_HOLD;
		end
		if (state_q == ST_UPDATE && out_free) begin
			for (int i = 0; i < kua_pkg::TABLE_ENTRIES; i++) begin
				if (hit_any_q) begin
					if (hit_q[i]) cmds[i] = kua_pkg::CMD_ADD;
				end else if (count_q == kua_pkg::CNT_W'(i)) begin
					cmds[i] = kua_pkg::CMD_CLAIM;
				end
			end
		end else if (scan_step) begin
			for (int i = 0; i < kua_pkg::TABLE_ENTRIES; i++) begin
				cmds[i] = kua_pkg::CMD_SHIFT;
			end
		end
	end

	kua_cell_row u_row (
		.clk     (clk),
		.cmds    (cmds),
		.req     (req_q),
		.sel     (hit_q),
		.match   (match),
		.head    (head),
		.sel_cpu (sel_cpu),
		.sel_mem (sel_mem)
	);

	// configuration registers, limits stored times ten
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_lim10_q <= kua_pkg::CPU_L10_RST;
			mem_lim10_q <= kua_pkg::MEM_L10_RST;
			win_q       <= kua_pkg::WIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				kua_pkg::REG_CPU_LIMIT:
					cpu_lim10_q <= {1'b0, cfg_data[kua_pkg::CPU_LIM_W-1:0], 3'b000}
						+ {3'b000, cfg_data[kua_pkg::CPU_LIM_W-1:0], 1'b0};
				kua_pkg::REG_MEM_LIMIT:
					mem_lim10_q <= {1'b0, cfg_data[kua_pkg::MEM_LIM_W-1:0], 3'b000}
						+ {3'b000, cfg_data[kua_pkg::MEM_LIM_W-1:0], 1'b0};
				kua_pkg::REG_WINDOW:
					win_q <= cfg_data[kua_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// thresholds: limit times ten times window
	always_ff @(posedge clk) begin
		cpu_thr_q <= kua_pkg::CPU_THR_W'(cpu_lim10_q) * kua_pkg::CPU_THR_W'(win_q);
		mem_thr_q <= kua_pkg::MEM_THR_W'(mem_lim10_q) * kua_pkg::MEM_THR_W'(win_q);
	end

	// request payload and match vector
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.id      <= proc_id;
			req_q.cpu     <= kua_pkg::CPU_W'(cpu_tenths);
			req_q.mem     <= kua_pkg::MEM_W'(mem_tenths);
			req_q.trusted <= is_trusted;
		end
		if (state_q == ST_MATCH) begin
			hit_q     <= match & used;
			hit_any_q <= |(match & used);
		end
		if (scan_step && head_hit) begin
			pend_q <= head;
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			scan_idx_q   <= '0;
			nhits_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			kind_q       <= kua_pkg::KIND_TAKEN;
			out_id_q     <= '0;
			cpu_total_q  <= '0;
			mem_total_q  <= '0;
			last_q       <= 1'b0;
		end else begin
			out_valid_q <= out_load | (out_valid_q & ~out_ready);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (operation)
							kua_pkg::OP_CLEAR:  count_q <= '0;
							kua_pkg::OP_SAMPLE: state_q <= ST_MATCH;
							kua_pkg::OP_REPORT: begin
								state_q      <= ST_SCAN;
								scan_idx_q   <= '0;
								nhits_q      <= '0;
								pend_valid_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_MATCH: state_q <= ST_UPDATE;
				ST_UPDATE: begin
					if (out_free) begin
						out_id_q    <= req_q.id;
						last_q      <= 1'b1;
						if (hit_any_q) begin
							kind_q      <= kua_pkg::KIND_TAKEN;
							cpu_total_q <= sel_cpu;
							mem_total_q <= sel_mem;
						end else if (!table_full) begin
							kind_q      <= kua_pkg::KIND_TAKEN;
							cpu_total_q <= req_q.cpu;
							mem_total_q <= req_q.mem;
							count_q     <= count_q + kua_pkg::CNT_W'(1);
						end else begin
							kind_q      <= kua_pkg::KIND_DROPPED;
							cpu_total_q <= '0;
							mem_total_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (scan_step) begin
						if (head_hit) begin
							// a newer hit releases the held one, not final
							if (pend_valid_q) begin
								kind_q      <= kua_pkg::KIND_SUSPECT;
								out_id_q    <= pend_q.id;
								cpu_total_q <= pend_q.cpu;
								mem_total_q <= pend_q.mem;
								last_q      <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							nhits_q      <= nhits_q + kua_pkg::HITS_W'(1);
						end
						scan_idx_q <= scan_idx_q + kua_pkg::IDX_W'(1);
						if (scan_idx_q == kua_pkg::IDX_W'(kua_pkg::TABLE_ENTRIES - 1)) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						last_q      <= 1'b1;
						if (pend_valid_q) begin
							kind_q      <= kua_pkg::KIND_SUSPECT;
							out_id_q    <= pend_q.id;
							cpu_total_q <= pend_q.cpu;
							mem_total_q <= pend_q.mem;
						end else begin
							kind_q      <= kua_pkg::KIND_NONE;
							out_id_q    <= '0;
							cpu_total_q <= '0;
							mem_total_q <= '0;
						end
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[design/kua_cell.sv]
// ----------------------------------------------------------------------------
// kua_cell: one slot of the usage table
// Holds one slot, compares it against the request id, accumulates with
// saturation, takes a new claim, or takes its neighbor's slot on a shift.
// ----------------------------------------------------------------------------
module kua_cell (
	input  logic               clk,
	input  kua_pkg::cell_cmd_t cmd,
	input  kua_pkg::slot_t     req,
	input  kua_pkg::slot_t     nbr,
	output kua_pkg::slot_t     slot,
	output logic               match,
	output logic [kua_pkg::CPU_W-1:0] sum_cpu,
	output logic [kua_pkg::MEM_W-1:0] sum_mem
);

	kua_pkg::slot_t slot_q;
	logic [kua_pkg::CPU_W:0] cpu_wide;
	logic [kua_pkg::MEM_W:0] mem_wide;

	// saturating sums of this slot plus the request
	always_comb begin
		cpu_wide = {1'b0, slot_q.cpu} + {1'b0, req.cpu};
		mem_wide = {1'b0, slot_q.mem} + {1'b0, req.mem};
		sum_cpu  = cpu_wide[kua_pkg::CPU_W] ? {kua_pkg::CPU_W{1'b1}}
			: cpu_wide[kua_pkg::CPU_W-1:0];
		sum_mem  = mem_wide[kua_pkg::MEM_W] ? {kua_pkg::MEM_W{1'b1}}
			: mem_wide[kua_pkg::MEM_W-1:0];
	end

	assign match = (slot_q.id == req.id);
	assign slot  = slot_q;

	// slot storage, no reset: validity is kept by the fill count
	always_ff @(posedge clk) begin
		case (cmd)
			kua_pkg::CMD_ADD: begin
				slot_q.cpu <= sum_cpu;
				slot_q.mem <= sum_mem;
			end
			kua_pkg::CMD_CLAIM: slot_q <= req;
			kua_pkg::CMD_SHIFT: slot_q <= nbr;
			default: slot_q <= slot_q;
		endcase
	end

endmodule

[design/kua_cell_row.sv]
// ----------------------------------------------------------------------------
// kua_cell_row: ring of table cells
// Cell i shifts in from cell i+1 and the last cell from cell 0, so a full
// rotation walks every slot past the head cell and restores the table.
// ----------------------------------------------------------------------------
module kua_cell_row (
	input  logic                                   clk,
	input  kua_pkg::cell_cmd_t [kua_pkg::TABLE_ENTRIES-1:0] cmds,
	input  kua_pkg::slot_t                         req,
	input  logic [kua_pkg::TABLE_ENTRIES-1:0]      sel,
	output logic [kua_pkg::TABLE_ENTRIES-1:0]      match,
	output kua_pkg::slot_t                         head,
	output logic [kua_pkg::CPU_W-1:0]              sel_cpu,
	output logic [kua_pkg::MEM_W-1:0]              sel_mem
);

	kua_pkg::slot_t [kua_pkg::TABLE_ENTRIES-1:0] slots;
	logic [kua_pkg::TABLE_ENTRIES-1:0][kua_pkg::CPU_W-1:0] sums_cpu;
	logic [kua_pkg::TABLE_ENTRIES-1:0][kua_pkg::MEM_W-1:0] sums_mem;

	// the cells, chained into a ring
	for (genvar i = 0; i < kua_pkg::TABLE_ENTRIES; i++) begin : g_cell
		kua_cell u_cell (
			.clk     (clk),
			.cmd     (cmds[i]),
			.req     (req),
			.nbr     (slots[(i + 1) % kua_pkg::TABLE_ENTRIES]),
			.slot    (slots[i]),
			.match   (match[i]),
			.sum_cpu (sums_cpu[i]),
			.sum_mem (sums_mem[i])
		);
	end

	assign head = slots[0];

	// one-hot pick of the updated sums
	always_comb begin
		sel_cpu = '0;
		sel_mem = '0;
		for (int i = 0; i < kua_pkg::TABLE_ENTRIES; i++) begin
			sel_cpu = sel_cpu | (sums_cpu[i] & {kua_pkg::CPU_W{sel[i]}});
			sel_mem = sel_mem | (sums_mem[i] & {kua_pkg::MEM_W{sel[i]}});
		end
	end

endmodule
